@@ hdl/gbwb_pkg.sv @@
// shared constants and types of the glyph bitmap window blitter
package gbwb_pkg;

    localparam int LINE_WIDTH  = 320;
    localparam int WINDOW_ROWS = 40;

    localparam int IDX_W   = 14;
    localparam int COLOR_W = 24;
    localparam int POS_W   = 12;
    localparam int ROW_W   = 10;
    localparam int CNT_W   = 8;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'h363636;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_BITMAP = 1'b1;

    // one bitmap byte with the glyph geometry it needs
    typedef struct packed {
        logic [7:0]       bits;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] width;
        logic [POS_W-1:0] origin_x;
        logic [POS_W-1:0] top_y;
        logic [ROW_W-1:0] win_top;
        logic [ROW_W-1:0] win_bottom;
    } t_entry;

endpackage

@@ hdl/glyph_bitmap_window_blit.sv @@
// top level of the glyph bitmap window blitter
// usage: the input stream carries glyph headers (tuser 0) and bitmap bytes
// (tuser 1). a header opens a glyph and gives no output. each bitmap byte
// yields up to eight pixel-write transactions on the output stream, one per
// lit bit that lands inside the window and the line; tlast marks the final
// write caused by that byte.
// the config channel loads the 24-bit text color; write it only while idle.
// throughput: the pixel engine handles one bitmap bit per cycle while the output
// is not stalled, walking all eight bits of a byte with live pixels; headers and
// bytes with no lit live pixel are taken by the front end and never reach the engine.
// a write passes through the queue, the engine's byte register, a pending register
// and the output register; it is held pending until the next hit or the end of the
// byte shows whether it is the last one.
// a two-entry queue decouples the front end from the engine, so input keeps
// flowing while the engine works and the output register waits.
// when the receiver stalls, the output holds, the engine stops and the queue
// fills; tready on the input drops only when the queue is full.
// reset: synchronous active low, clears cursor, queue and output valid; the
// color returns to 0x363636 and no glyph is open.
module glyph_bitmap_window_blit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // pen_x, base_row, glyph_width, glyph_height, offset_x, offset_y,
    // window_top, window_bottom, bitmap_byte
    input  logic [79:0] i_s_axis_tdata,
    // mode
    input  logic        i_s_axis_tuser,
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // buffer_index, pixel_color, two zero bits
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    logic [gbwb_pkg::COLOR_W-1:0] r_text_color;

    // front to queue
    logic             push;
    gbwb_pkg::t_entry push_entry;
    logic             q_full;

    // queue to engine
    logic             q_empty;
    logic             pop;
    gbwb_pkg::t_entry head;

    logic [gbwb_pkg::IDX_W-1:0] out_idx;

    // color register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= gbwb_pkg::COLOR_RESET;
        end else if (i_cfg_valid) begin
            r_text_color <= i_cfg_data;
        end
    end

    gbwb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_mode  (i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .i_full  (q_full),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    gbwb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    gbwb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_index (out_idx),
        .o_last  (o_m_axis_tlast)
    );

    // the user must keep the color stable while writes are in flight; the block does not enforce it
    assign o_m_axis_tdata = {2'b00, r_text_color, out_idx};

endmodule

@@ hdl/gbwb_front.sv @@
// front end: takes headers and bitmap bytes, tracks the glyph cursor, queues work
module gbwb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_mode,
    input  logic [79:0]           i_data,
    input  logic                  i_full,
    output logic                  o_ready,
    output logic                  o_push,
    output gbwb_pkg::t_entry      o_entry
);

    logic [gbwb_pkg::POS_W-1:0] r_origin_x;
    logic [gbwb_pkg::POS_W-1:0] r_top_y;
    logic [gbwb_pkg::CNT_W-1:0] r_box_w;
    logic [gbwb_pkg::CNT_W-1:0] r_box_h;
    logic [gbwb_pkg::CNT_W-1:0] r_row;
    logic [gbwb_pkg::CNT_W-1:0] r_col;
    logic [gbwb_pkg::ROW_W-1:0] r_win_top;
    logic [gbwb_pkg::ROW_W-1:0] r_win_bot;
    logic                       r_active;

    logic [gbwb_pkg::CNT_W-1:0] n_row;
    logic [gbwb_pkg::CNT_W-1:0] n_col;
    logic                       n_active;
    logic [7:0]                 live_mask;
    logic [7:0]                 live_bits;
    logic                       accept;

    logic [9:0] pen_x;
    logic [9:0] base_y;
    logic [7:0] gw;
    logic [7:0] gh;
    logic [7:0] ox;
    logic [7:0] oy;
    logic [9:0] wt;
    logic [9:0] wb;
    logic [7:0] byte_in;

    assign pen_x   = i_data[9:0];
    assign base_y  = i_data[19:10];
    assign gw      = i_data[27:20];
    assign gh      = i_data[35:28];
    assign ox      = i_data[43:36];
    assign oy      = i_data[51:44];
    assign wt      = i_data[61:52];
    assign wb      = i_data[71:62];
    assign byte_in = i_data[79:72];

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // walk the eight pixels of one byte through the glyph box
    always_comb begin
        logic [gbwb_pkg::CNT_W-1:0] row;
        logic [gbwb_pkg::CNT_W-1:0] col;
        logic                       act;
        row = r_row;
        col = r_col;
        act = r_active;
        live_mask = '0;
        for (int k = 7; k >= 0; k--) begin
            live_mask[k] = act;
            if (act) begin
                col = col + 8'd1;
                if (col >= r_box_w) begin
                    col = '0;
                    row = row + 8'd1;
                    if (row >= r_box_h) begin
                        act = 1'b0;
                    end
                end
            end
        end
        n_row    = row;
        n_col    = col;
        n_active = act;
    end

    assign live_bits = byte_in & live_mask;
    assign o_push    = accept && (i_mode == gbwb_pkg::MODE_BITMAP) && (live_bits != 8'd0);

    always_comb begin
        o_entry.bits       = live_bits;
        o_entry.row        = r_row;
        o_entry.col        = r_col;
        o_entry.width      = r_box_w;
        o_entry.origin_x   = r_origin_x;
        o_entry.top_y      = r_top_y;
        o_entry.win_top    = r_win_top;
        o_entry.win_bottom = r_win_bot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_top_y    <= '0;
            r_box_w    <= '0;
            r_box_h    <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_win_top  <= '0;
            r_win_bot  <= '0;
            r_active   <= 1'b0;
        end else if (accept) begin
            if (i_mode == gbwb_pkg::MODE_HEADER) begin
                r_origin_x <= {2'b00, pen_x} + {{4{ox[7]}}, ox};
                r_top_y    <= {2'b00, base_y} - {{4{oy[7]}}, oy} - {4'b0000, gh} - 12'd1;
                r_box_w    <= gw;
                r_box_h    <= gh;
                r_row      <= '0;
                r_col      <= '0;
                r_win_top  <= wt;
                r_win_bot  <= wb;
                r_active   <= (gw != 8'd0) && (gh != 8'd0);
            end else begin
                r_row    <= n_row;
                r_col    <= n_col;
                r_active <= n_active;
            end
        end
    end

endmodule

@@ hdl/gbwb_queue.sv @@
// two-entry queue between the front end and the pixel engine
module gbwb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gbwb_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output gbwb_pkg::t_entry o_head
);

    gbwb_pkg::t_entry r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

@@ hdl/gbwb_back.sv @@
// pixel engine: one bit per cycle unless the output stalls, window clipping, index, last marking
module gbwb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  gbwb_pkg::t_entry             i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [gbwb_pkg::IDX_W-1:0]   o_index,
    output logic                         o_last
);

    logic                       r_act;
    gbwb_pkg::t_entry           r_ent;
    logic [2:0]                 r_pos;
    logic [gbwb_pkg::CNT_W-1:0] r_row;
    logic [gbwb_pkg::CNT_W-1:0] r_col;
    logic                       r_pend_v;
    logic                       r_pend_fin;
    logic [gbwb_pkg::IDX_W-1:0] r_pend_idx;
    logic                       r_ov;
    logic [gbwb_pkg::IDX_W-1:0] r_oidx;
    logic                       r_olast;

    logic                       bit_set;
    logic signed [12:0]         y;
    logic signed [12:0]         x;
    logic signed [12:0]         by;
    logic                       in_win;
    logic                       hit;
    logic [gbwb_pkg::IDX_W-1:0] idx;
    logic                       at_end;
    logic                       emit_fin;
    logic                       emit_mid;
    logic                       emit;
    logic                       emit_last;
    logic                       go;
    logic                       load;
    logic [gbwb_pkg::CNT_W-1:0] col_inc;

    assign bit_set = r_ent.bits[3'd7 - r_pos];
    assign y  = $signed({r_ent.top_y[11], r_ent.top_y}) + $signed({5'b0, r_row});
    assign x  = $signed({r_ent.origin_x[11], r_ent.origin_x}) + $signed({5'b0, r_col});
    assign by = y - $signed({3'b000, r_ent.win_top});

    assign in_win = (y >= $signed({3'b000, r_ent.win_top}))
                 && (y <= $signed({3'b000, r_ent.win_bottom}))
                 && (by <= $signed(13'(gbwb_pkg::WINDOW_ROWS - 1)))
                 && !x[12]
                 && (x <= $signed(13'(gbwb_pkg::LINE_WIDTH - 1)));
    assign hit = r_act && bit_set && in_win;
    assign idx = {7'b0, by[6:0]} * gbwb_pkg::IDX_W'(gbwb_pkg::LINE_WIDTH)
               + {1'b0, x};

    assign at_end    = (r_pos == 3'd7);
    assign emit_fin  = r_pend_v && r_pend_fin;
    assign emit_mid  = r_act && r_pend_v && !r_pend_fin && (hit || at_end);
    assign emit      = emit_fin || emit_mid;
    assign emit_last = emit_fin || (at_end && !hit);
    assign go        = !emit || !r_ov || i_ready;
    assign load      = go && !i_empty && (!r_act || at_end);
    assign o_pop     = load;
    assign col_inc   = r_col + 8'd1;

    assign o_valid = r_ov;
    assign o_index = r_oidx;
    assign o_last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_oidx  <= r_pend_idx;
            r_olast <= emit_last;
        end
        if (go && hit) begin
            r_pend_idx <= idx;
        end
        if (load) begin
            r_ent <= i_head;
            r_row <= i_head.row;
            r_col <= i_head.col;
        end else if (go && r_act) begin
            if (col_inc >= r_ent.width) begin
                r_col <= '0;
                r_row <= r_row + 8'd1;
            end else begin
                r_col <= col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 1'b0;
            r_pos      <= '0;
            r_pend_v   <= 1'b0;
            r_pend_fin <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (go && emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (go) begin
                if (hit) begin
                    r_pend_v   <= 1'b1;
                    r_pend_fin <= at_end;
                end else if (emit) begin
                    r_pend_v   <= 1'b0;
                    r_pend_fin <= 1'b0;
                end
                if (load) begin
                    r_act <= 1'b1;
                    r_pos <= '0;
                end else if (r_act) begin
                    if (at_end) begin
                        r_act <= 1'b0;
                    end
                    r_pos <= r_pos + 3'd1;
                end
            end
        end
    end

endmodule

@@ tb/sv/glyph_bitmap_window_blit_checker.sv @@
// pixel write predictor and scoreboard for the glyph bitmap window blitter
module glyph_bitmap_window_blit_checker
    import gbwb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [79:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel_write;

    t_pixel_write pixel_writes[$];

    // predicted block state
    logic [COLOR_W-1:0] text_color;
    int                 origin_x;
    int                 top_row_y;
    int                 win_top;
    int                 win_bottom;
    logic [CNT_W-1:0]   box_width;
    logic [CNT_W-1:0]   box_height;
    logic [CNT_W-1:0]   row_count;
    logic [CNT_W-1:0]   col_count;
    bit                 glyph_open;

    task automatic report_mismatch(input string what);
        o_fail_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic load_glyph_header(input logic [79:0] d);
        origin_x   = int'(d[9:0]) + int'($signed(d[43:36]));
        box_width  = d[27:20];
        box_height = d[35:28];
        top_row_y  = int'(d[19:10]) - int'($signed(d[51:44])) - int'(box_height) - 1;
        win_top    = int'(d[61:52]);
        win_bottom = int'(d[71:62]);
        row_count  = '0;
        col_count  = '0;
        glyph_open = (box_width != 0) && (box_height != 0);
    endtask

    // walks the byte MSB first, advancing the glyph cursor one pixel per bit
    task automatic rasterize_byte(input logic [7:0] bits);
        t_pixel_write hits[$];
        t_pixel_write w;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        int y;
        int x;
        int band_row;
        int idx;
        for (int b = 7; b >= 0 && glyph_open; b--) begin
            row = row_count;
            col = col_count;
            col_count++;
            if (col_count >= box_width) begin
                col_count = '0;
                row_count++;
                if (row_count >= box_height)
                    glyph_open = 0;
            end
            if (bits[b]) begin
                y = top_row_y + int'(row);
                x = origin_x + int'(col);
                if (y < win_top || y > win_bottom)
                    continue;
                band_row = y - win_top;
                if (band_row > WINDOW_ROWS - 1)
                    continue;
                if (x < 0 || x > LINE_WIDTH - 1)
                    continue;
                idx = band_row * LINE_WIDTH + x;
                if (idx > LINE_WIDTH * WINDOW_ROWS - 1)
                    idx = LINE_WIDTH * WINDOW_ROWS - 1;
                w.index = idx[IDX_W-1:0];
                w.color = text_color;
                w.last  = 1'b0;
                hits.push_back(w);
            end
        end
        if (hits.size() > 0)
            hits[hits.size()-1].last = 1'b1;
        foreach (hits[i])
            pixel_writes.push_back(hits[i]);
    endtask

    always @(posedge i_clk) begin
        t_pixel_write exp_w;
        if (!i_rst_n) begin
            o_fail_count = 0;
            text_color = COLOR_RESET;
            origin_x   = 0;
            top_row_y  = 0;
            win_top    = 0;
            win_bottom = 0;
            box_width  = '0;
            box_height = '0;
            row_count  = '0;
            col_count  = '0;
            glyph_open = 0;
            pixel_writes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                text_color = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                if (i_in_user == MODE_HEADER)
                    load_glyph_header(i_in_data);
                else
                    rasterize_byte(i_in_data[79:72]);
            end
            if (i_out_valid && i_out_ready) begin
                if (pixel_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected write index %0d",
                                              i_out_data[13:0]));
                end else begin
                    exp_w = pixel_writes.pop_front();
                    if (i_out_data[13:0] !== exp_w.index)
                        report_mismatch($sformatf("index %0d, predicted %0d",
                                                  i_out_data[13:0], exp_w.index));
                    if (i_out_data[37:14] !== exp_w.color)
                        report_mismatch($sformatf("color %h, predicted %h",
                                                  i_out_data[37:14], exp_w.color));
                    if (i_out_last !== exp_w.last)
                        report_mismatch($sformatf("last %b, predicted %b",
                                                  i_out_last, exp_w.last));
                    if (i_out_data[39:38] !== 2'b00)
                        report_mismatch($sformatf("padding bits %b", i_out_data[39:38]));
                end
            end
        end
        o_pending <= pixel_writes.size();
    end

endmodule

@@ tb/sv/glyph_bitmap_window_blit_tb.sv @@
// stimulus and verdict for the glyph bitmap window blitter
module glyph_bitmap_window_blit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gbwb_pkg::*;

    // generous bound: ~250 items, up to 8 writes each, heavy stalls, one long hold
    localparam int CYCLE_LIMIT  = 300000;
    // extra wait after every predicted write has been seen, so the engine can go quiet
    localparam int SETTLE_TICKS = 20;
    localparam int HOLD_TICKS   = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // pen_x, base_row, glyph_width, glyph_height, offset_x, offset_y,
    // window_top, window_bottom, bitmap_byte
    logic [79:0] i_s_axis_tdata = '0;
    // mode
    logic        i_s_axis_tuser = MODE_HEADER;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // buffer_index, pixel_color, two zero bits
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data = '0;

    int fail_count;
    int writes_pending;
    int cycle_count = 0;

    // idling knobs, in percent per cycle
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    // long receiver hold-off: the stimulus bumps the request, the hold process counts it out
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always #5 i_clk = ~i_clk;

    glyph_bitmap_window_blit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    glyph_bitmap_window_blit_checker pixel_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata),
        .i_in_user    (i_s_axis_tuser),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_out_last   (o_m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (writes_pending)
    );

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("glyph_bitmap_window_blit verification failed");
            $finish;
        end
    end

    // hold-off counter, restarted whenever a new request shows up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_seen != hold_req) begin
            hold_left <= HOLD_TICKS;
            hold_seen <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: random stalls, fully blocked during a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // offers one transaction; valid stays high into the next call unless a gap is taken
    task automatic send_raw(input logic mode, input logic [79:0] d);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // header fields from plain integers; the bitmap byte lane carries junk
    task automatic send_header(input int px, input int bl, input int w, input int h,
                               input int ox, input int oy, input int wt, input int wb);
        logic [79:0] d;
        d = 80'({$urandom(), $urandom(), $urandom()});
        d[9:0]   = px[9:0];
        d[19:10] = bl[9:0];
        d[27:20] = w[7:0];
        d[35:28] = h[7:0];
        d[43:36] = ox[7:0];
        d[51:44] = oy[7:0];
        d[61:52] = wt[9:0];
        d[71:62] = wb[9:0];
        send_raw(MODE_HEADER, d);
    endtask

    // bitmap byte; the header lanes carry junk that must be ignored
    task automatic send_byte(input logic [7:0] bits);
        logic [79:0] d;
        d = 80'({$urandom(), $urandom(), $urandom()});
        d[79:72] = bits;
        send_raw(MODE_BITMAP, d);
    endtask

    // drop valid, wait for every predicted write, then let the engine go quiet
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (writes_pending != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [23:0] color);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= color;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int clamp_row(input int v);
        if (v < 0)
            return 0;
        if (v > 1023)
            return 1023;
        return v;
    endfunction

    // mostly small sizes, now and then an empty or a huge box
    function automatic int pick_box_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(17, 255);
        return $urandom_range(1, 12);
    endfunction

    // one glyph: header placed near the window, then its bitmap bytes
    task automatic random_glyph(output int n_items);
        int w, h, px, bl, ox, oy, top, wt, wb, nbytes, r;
        logic [7:0] bits;
        w  = pick_box_size();
        h  = pick_box_size();
        px = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 1023) : $urandom_range(0, 330);
        ox = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 255)) - 128
                                         : int'($urandom_range(0, 12)) - 6;
        bl = $urandom_range(0, 1023);
        oy = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 255)) - 128
                                         : int'($urandom_range(0, 12)) - 6;
        top = bl - oy - h - 1;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            wt = $urandom_range(0, 1023);
            wb = $urandom_range(0, 1023);
        end else if (r == 1) begin
            // inverted window
            wt = clamp_row(top);
            wb = clamp_row(wt - int'($urandom_range(1, 20)));
        end else begin
            wt = clamp_row(top + int'($urandom_range(0, 10)) - 5);
            wb = clamp_row(wt + int'($urandom_range(0, 50)));
        end
        send_header(px, bl, w, h, ox, oy, wt, wb);
        nbytes = (w * h + 7) / 8;
        // big glyphs are cut short; the next header reopens the cursor
        if (nbytes > 10)
            nbytes = $urandom_range(1, 10);
        n_items = 1 + nbytes;
        // occasionally a byte past the end of the glyph
        if ($urandom_range(0, 3) == 0)
            nbytes++;
        repeat (nbytes) begin
            r = $urandom_range(0, 5);
            bits = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom());
            send_byte(bits);
        end
    endtask

    task automatic random_phase(input int target);
        int sent;
        int n;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any mode, any payload
                send_raw(1'($urandom()), 80'({$urandom(), $urandom(), $urandom()}));
            end else begin
                random_glyph(n);
                sent += n;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners, no idling, reset color
        send_byte(8'hFF);                                   // no glyph open yet
        send_header(10, 20, 0, 5, 0, 0, 0, 1023);           // zero width, stays closed
        send_byte(8'hFF);
        send_header(10, 20, 5, 0, 0, 0, 0, 1023);           // zero height, stays closed
        send_byte(8'hAA);
        send_header(10, 20, 3, 2, 0, 0, 17, 18);            // 3x2 glyph inside the window
        send_byte(8'hFF);                                   // two trailing bits ignored
        send_byte(8'hFF);                                   // glyph already closed
        send_header(2, 100, 8, 1, -4, 0, 98, 98);           // first columns negative
        send_byte(8'hFF);
        send_header(1023, 100, 8, 1, 127, 0, 98, 98);       // entirely right of the line
        send_byte(8'hFF);
        send_header(316, 100, 8, 1, 0, 0, 98, 98);          // clipped at the line end
        send_byte(8'hFF);
        send_header(50, 60, 8, 2, 0, 0, 100, 50);           // inverted window
        send_byte(8'hFF);
        send_header(319, 45, 1, 8, 0, 0, 0, 1023);          // runs past the band depth
        send_byte(8'hFF);                                   // last write hits index 12799
        send_header(0, 1023, 255, 255, 0, -128, 896, 1023); // largest box, row above window
        send_byte(8'hFF);
        send_header(0, 0, 8, 1, 0, 127, 0, 0);              // rows above the screen
        send_byte(8'h81);
        send_header(40, 500, 2, 4, 0, 0, 470, 496);         // rows below window bottom
        send_byte(8'hFF);
        send_byte(8'h55);

        // phase 0: no idling, with one long receiver hold-off to fill the queue
        hold_req <= hold_req + 1;
        random_phase(45);
        settle();

        // phase 1: sender idles, color at its lowest
        write_color(24'h000000);
        src_idle_pct = 66;
        sink_stall_pct <= 0;
        random_phase(50);
        settle();

        // phase 2: receiver stalls, color at its highest
        write_color(24'hFFFFFF);
        src_idle_pct = 0;
        sink_stall_pct <= 66;
        random_phase(50);
        settle();

        // phase 3: both sides idle, random color
        write_color(24'($urandom()));
        src_idle_pct = 33;
        sink_stall_pct <= 33;
        random_phase(50);
        settle();

        if (fail_count == 0 && writes_pending == 0) begin
            $display("glyph_bitmap_window_blit verification clean");
        end else begin
            $display("glyph_bitmap_window_blit verification failed");
        end
        $finish;
    end

endmodule
